/* src/lcpf_pkg.sv */
// Shared types and constants for the LSTM cell pointwise forward block.
// Holds the item/result structs, fixed-point formats and activation constants.
// No dependencies.
package lcpf_pkg;

	localparam int DATA_W = 16;
	localparam int FRAC_W = 12;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		data_t pre_input_gate;
		data_t pre_forget_gate;
		data_t pre_candidate;
		data_t pre_output_gate;
		data_t prev_cell;
		data_t prev_hidden;
		logic  keep_hidden;
		logic  keep_cell;
	} item_t;

	typedef struct packed {
		data_t cell_out;
		data_t hidden_out;
		data_t cell_raw;
	} result_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FORGET_BIAS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONEOUT_EN  = 2'd1;

	// activation argument: wide enough for the unsaturated cell sum
	localparam int ACT_X_W = 19;
	typedef logic signed [ACT_X_W-1:0] act_x_t;

	localparam int EXP_ARG_W = 18;
	localparam int Q_SHIFT   = 32 - FRAC_W;
	localparam int RND_SHIFT = 31 - FRAC_W;
	localparam int Q_W       = EXP_ARG_W + Q_SHIFT;
	localparam logic [ACT_X_W-1:0] SIG_LIM  = ACT_X_W'(32 << FRAC_W);
	localparam logic [ACT_X_W-1:0] TANH_LIM = ACT_X_W'(16 << FRAC_W);

	localparam logic [63:0] LN2_Q32     = 64'd2977044472;
	localparam int          LN2_RCP_SH  = 24;
	localparam int          LN2_RCP_W   = 13;
	localparam logic [63:0] LN2_RCP_FULL = (64'd1 << (Q_SHIFT + LN2_RCP_SH)) / LN2_Q32;
	localparam int          K_W         = 6;
	localparam int          EXP_CUT     = 40;

	localparam int TAYLOR_N = 14;
	localparam logic [32:0] RECIP [1:TAYLOR_N] = '{
		33'((64'd1 << 32) / 64'd1),  33'((64'd1 << 32) / 64'd2),
		33'((64'd1 << 32) / 64'd3),  33'((64'd1 << 32) / 64'd4),
		33'((64'd1 << 32) / 64'd5),  33'((64'd1 << 32) / 64'd6),
		33'((64'd1 << 32) / 64'd7),  33'((64'd1 << 32) / 64'd8),
		33'((64'd1 << 32) / 64'd9),  33'((64'd1 << 32) / 64'd10),
		33'((64'd1 << 32) / 64'd11), 33'((64'd1 << 32) / 64'd12),
		33'((64'd1 << 32) / 64'd13), 33'((64'd1 << 32) / 64'd14)
	};

	localparam int DIV_STEPS = 31;
	localparam int ACT_LAT   = 4 + 3 * TAYLOR_N + 2 + DIV_STEPS + 1;
	localparam int TOP_LAT   = 2 * ACT_LAT + 4;

	function automatic data_t sat_data(input logic signed [21:0] v);
		logic signed [21:0] hi;
		logic signed [21:0] lo;
		hi = 22'sd32767;
		lo = -22'sd32768;
		if (v > hi) begin
			return data_t'(hi);
		end else if (v < lo) begin
			return data_t'(lo);
		end
		return data_t'(v);
	endfunction

endpackage

/* src/lstm_cell_pointwise_forward.sv */
// LSTM cell pointwise forward step with zoneout, Q3.12 fixed point.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Latency is set by two activation pipelines in series (gates, then tanh of cell).
// Reset clears all valid bits and the config registers (bias 0, zoneout off).
module lstm_cell_pointwise_forward (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lcpf_pkg::item_t               item,
	output logic                          done,
	output lcpf_pkg::result_t             result,
	input  logic                          cfg_we,
	input  logic [lcpf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  lcpf_pkg::data_t               cfg_wdata
);
	import lcpf_pkg::*;

	typedef struct packed {
		data_t pc;
		data_t ph;
		logic  kh;
		logic  kc;
	} side_t;

	typedef struct packed {
		side_t s;
		data_t craw;
		data_t og;
	} side2_t;

	data_t bias_q;
	logic  zone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			zone_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_FORGET_BIAS) begin
				bias_q <= cfg_wdata;
			end else if (cfg_idx == CFG_ZONEOUT_EN) begin
				zone_q <= cfg_wdata[0];
			end
		end
	end

	assign busy = 1'b0;

	// gate activations
	logic  gv_i, gv_f, gv_c, gv_o;
	data_t ig, fg, cg, og;
	act_x_t fx;

	assign fx = act_x_t'(item.pre_forget_gate) + act_x_t'(bias_q);

	lcpf_act u_act_i (.clk, .arst_n, .in_valid(start), .tanh_mode(1'b0),
		.x(act_x_t'(item.pre_input_gate)), .out_valid(gv_i), .y(ig));
	lcpf_act u_act_f (.clk, .arst_n, .in_valid(start), .tanh_mode(1'b0),
		.x(fx), .out_valid(gv_f), .y(fg));
	lcpf_act u_act_c (.clk, .arst_n, .in_valid(start), .tanh_mode(1'b1),
		.x(act_x_t'(item.pre_candidate)), .out_valid(gv_c), .y(cg));
	lcpf_act u_act_o (.clk, .arst_n, .in_valid(start), .tanh_mode(1'b0),
		.x(act_x_t'(item.pre_output_gate)), .out_valid(gv_o), .y(og));

	// hold side data alongside the gate pipeline
	side_t sa_q [0:ACT_LAT-1];

	always_ff @(posedge clk) begin
		sa_q[0] <= '{pc: item.prev_cell, ph: item.prev_hidden,
			kh: item.keep_hidden, kc: item.keep_cell};
		for (int i = 1; i < ACT_LAT; i++) begin
			sa_q[i] <= sa_q[i-1];
		end
	end

	// products
	logic                 v_s1;
	logic signed [31:0]   m1_s1, m2_s1;
	side_t                side_s1;
	data_t                og_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= gv_i & gv_f & gv_c & gv_o;
		end
	end

	always_ff @(posedge clk) begin
		m1_s1   <= 32'(cg) * 32'(ig);
		m2_s1   <= 32'(sa_q[ACT_LAT-1].pc) * 32'(fg);
		side_s1 <= sa_q[ACT_LAT-1];
		og_s1   <= og;
	end

	// sum and round the cell
	logic signed [33:0] csum;
	logic               v_s2;
	act_x_t             cell_s2;
	side_t              side_s2;
	data_t              og_s2;

	assign csum = 34'(m1_s1) + 34'(m2_s1) + 34'sd2048;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cell_s2 <= act_x_t'(csum >>> FRAC_W);
		side_s2 <= side_s1;
		og_s2   <= og_s1;
	end

	// tanh of the unsaturated cell
	logic  tv;
	data_t th;

	lcpf_act u_act_h (.clk, .arst_n, .in_valid(v_s2), .tanh_mode(1'b1),
		.x(cell_s2), .out_valid(tv), .y(th));

	side2_t sb_q [0:ACT_LAT-1];

	always_ff @(posedge clk) begin
		sb_q[0] <= '{s: side_s2, craw: sat_data(22'(cell_s2)), og: og_s2};
		for (int i = 1; i < ACT_LAT; i++) begin
			sb_q[i] <= sb_q[i-1];
		end
	end

	// hidden product
	logic               v_s3;
	logic signed [31:0] hp_s3;
	side2_t             side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= tv;
		end
	end

	always_ff @(posedge clk) begin
		hp_s3   <= 32'(th) * 32'(sb_q[ACT_LAT-1].og);
		side_s3 <= sb_q[ACT_LAT-1];
	end

	// round, saturate and apply zoneout
	logic signed [31:0] hsum;
	data_t              hid;

	assign hsum = hp_s3 + 32'sd2048;
	assign hid  = sat_data(22'(hsum >>> FRAC_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		result.cell_raw   <= side_s3.craw;
		result.cell_out   <= (zone_q && !side_s3.s.kc) ? side_s3.s.pc : side_s3.craw;
		result.hidden_out <= (zone_q && !side_s3.s.kh) ? side_s3.s.ph : hid;
	end

endmodule

/* src/lcpf_act.sv */
// Pipelined sigmoid / tanh unit: exp(-|x|) by ln2 range reduction and a
// 14-term truncating Taylor series in Q32, then a bit-per-stage divider.
// Depends on lcpf_pkg.
module lcpf_act (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            tanh_mode,
	input  lcpf_pkg::act_x_t x,
	output logic            out_valid,
	output lcpf_pkg::data_t  y
);
	import lcpf_pkg::*;

	typedef struct packed {
		logic           valid;
		logic           neg;
		logic [K_W-1:0] k;
		logic [31:0]    r;
		logic [32:0]    term;
		logic [33:0]    pos;
		logic [32:0]    nacc;
	} tay_t;

	typedef struct packed {
		tay_t        base;
		logic [31:0] t;
		logic [31:0] qe;
	} tmid_t;

	typedef struct packed {
		logic        valid;
		logic        neg;
		logic [34:0] rem;
		logic [34:0] den;
		logic [DIV_STEPS-1:0] quo;
	} div_t;

	// stage 1: magnitude and clamp
	logic [ACT_X_W-1:0] mag;
	logic [ACT_X_W-1:0] lim;
	logic [ACT_X_W-1:0] clamped;
	logic [ACT_X_W:0]   arg_w;
	logic               v_s1, neg_s1;
	logic [EXP_ARG_W-1:0] arg_s1;

	assign mag     = x[ACT_X_W-1] ? ACT_X_W'(-x) : ACT_X_W'(x);
	assign lim     = tanh_mode ? TANH_LIM : SIG_LIM;
	assign clamped = (mag > lim) ? lim : mag;
	assign arg_w   = tanh_mode ? {clamped, 1'b0} : {1'b0, clamped};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			neg_s1 <= 1'b0;
			arg_s1 <= '0;
		end else begin
			v_s1   <= in_valid;
			neg_s1 <= x[ACT_X_W-1];
			arg_s1 <= EXP_ARG_W'(arg_w);
		end
	end

	// stage 2: estimate k = floor(q / ln2) by reciprocal
	logic [EXP_ARG_W+LN2_RCP_W-1:0] kprod;
	logic                 v_s2, neg_s2;
	logic [K_W-1:0]       kest_s2;
	logic [Q_W-1:0]       q_s2;

	assign kprod = (EXP_ARG_W+LN2_RCP_W)'(arg_s1)
		* (EXP_ARG_W+LN2_RCP_W)'(LN2_RCP_FULL[LN2_RCP_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			neg_s2  <= 1'b0;
			kest_s2 <= '0;
			q_s2    <= '0;
		end else begin
			v_s2    <= v_s1;
			neg_s2  <= neg_s1;
			kest_s2 <= K_W'(kprod >> LN2_RCP_SH);
			q_s2    <= Q_W'(arg_s1) << Q_SHIFT;
		end
	end

	// stage 3: k * ln2
	logic           v_s3, neg_s3;
	logic [K_W-1:0] k_s3;
	logic [Q_W-1:0] q_s3, p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			neg_s3 <= 1'b0;
			k_s3   <= '0;
			q_s3   <= '0;
			p_s3   <= '0;
		end else begin
			v_s3   <= v_s2;
			neg_s3 <= neg_s2;
			k_s3   <= kest_s2;
			q_s3   <= q_s2;
			p_s3   <= Q_W'(kest_s2) * Q_W'(LN2_Q32[31:0]);
		end
	end

	// stage 4: remainder and one correction step
	tay_t           tay_s [0:TAYLOR_N];
	logic [Q_W-1:0] r0;
	logic           r_over;

	assign r0     = q_s3 - p_s3;
	assign r_over = (r0 >= Q_W'(LN2_Q32[31:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tay_s[0] <= '0;
		end else begin
			tay_s[0].valid <= v_s3;
			tay_s[0].neg   <= neg_s3;
			tay_s[0].k     <= r_over ? k_s3 + K_W'(1) : k_s3;
			tay_s[0].r     <= r_over ? 32'(r0 - Q_W'(LN2_Q32[31:0])) : 32'(r0);
			tay_s[0].term  <= 33'h1_0000_0000;
			tay_s[0].pos   <= 34'h1_0000_0000;
			tay_s[0].nacc  <= '0;
		end
	end

	// series terms: multiply, reciprocal divide, correct and accumulate
	tmid_t ta_s [0:TAYLOR_N-1];
	tmid_t tb_s [0:TAYLOR_N-1];

	for (genvar j = 0; j < TAYLOR_N; j++) begin : g_term
		localparam int N = j + 1;
		logic [64:0] pa;
		logic [64:0] pb;
		logic [31:0] rem;
		logic [31:0] qc;

		assign pa  = 65'(tay_s[j].term) * 65'(tay_s[j].r);
		assign pb  = 65'(ta_s[j].t) * 65'(RECIP[N]);
		assign rem = tb_s[j].t - 32'(tb_s[j].qe * 32'(N));
		assign qc  = (rem >= 32'(N)) ? tb_s[j].qe + 32'd1 : tb_s[j].qe;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ta_s[j]    <= '0;
				tb_s[j]    <= '0;
				tay_s[j+1] <= '0;
			end else begin
				ta_s[j].base <= tay_s[j];
				ta_s[j].t    <= 32'(pa >> 32);
				ta_s[j].qe   <= '0;
				tb_s[j].base <= ta_s[j].base;
				tb_s[j].t    <= ta_s[j].t;
				tb_s[j].qe   <= 32'(pb >> 32);
				tay_s[j+1].valid <= tb_s[j].base.valid;
				tay_s[j+1].neg   <= tb_s[j].base.neg;
				tay_s[j+1].k     <= tb_s[j].base.k;
				tay_s[j+1].r     <= tb_s[j].base.r;
				tay_s[j+1].term  <= 33'(qc);
				if (N % 2 == 1) begin
					tay_s[j+1].nacc <= tb_s[j].base.nacc + 33'(qc);
					tay_s[j+1].pos  <= tb_s[j].base.pos;
				end else begin
					tay_s[j+1].nacc <= tb_s[j].base.nacc;
					tay_s[j+1].pos  <= tb_s[j].base.pos + 34'(qc);
				end
			end
		end
	end

	// scale by 2^-k
	logic [33:0] vsum;
	logic        v_e, neg_e;
	logic [33:0] e_e;

	assign vsum = tay_s[TAYLOR_N].pos - 34'(tay_s[TAYLOR_N].nacc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e   <= 1'b0;
			neg_e <= 1'b0;
			e_e   <= '0;
		end else begin
			v_e   <= tay_s[TAYLOR_N].valid;
			neg_e <= tay_s[TAYLOR_N].neg;
			e_e   <= (tay_s[TAYLOR_N].k >= K_W'(EXP_CUT)) ? '0 : vsum >> tay_s[TAYLOR_N].k;
		end
	end

	// divider setup and restoring steps
	div_t div_s [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0] <= '0;
		end else begin
			div_s[0].valid <= v_e;
			div_s[0].neg   <= neg_e;
			div_s[0].rem   <= tanh_mode ? 35'h1_0000_0000 - 35'(e_e) : 35'(e_e);
			div_s[0].den   <= 35'h1_0000_0000 + 35'(e_e);
			div_s[0].quo   <= '0;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [34:0] rem2;
		logic        take;

		assign rem2 = {div_s[j].rem[33:0], 1'b0};
		assign take = (rem2 >= div_s[j].den);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[j+1] <= '0;
			end else begin
				div_s[j+1].valid <= div_s[j].valid;
				div_s[j+1].neg   <= div_s[j].neg;
				div_s[j+1].den   <= div_s[j].den;
				div_s[j+1].rem   <= take ? rem2 - div_s[j].den : rem2;
				div_s[j+1].quo   <= {div_s[j].quo[DIV_STEPS-2:0], take};
			end
		end
	end

	// final: complement for sigmoid of positive x, round, apply sign
	logic [31:0] part;
	logic [31:0] sval;
	logic [31:0] rsum;
	data_t       rnd;

	assign part = 32'(div_s[DIV_STEPS].quo);
	assign sval = (tanh_mode || div_s[DIV_STEPS].neg) ? part : 32'h8000_0000 - part;
	assign rsum = sval + (32'd1 << (RND_SHIFT - 1));
	assign rnd  = data_t'(rsum >> RND_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			y         <= '0;
		end else begin
			out_valid <= div_s[DIV_STEPS].valid;
			y         <= (tanh_mode && div_s[DIV_STEPS].neg) ? -rnd : rnd;
		end
	end

endmodule

/* src/lcpf_chk.sv */
// Port-level checker for lstm_cell_pointwise_forward, bound to the top level.
// Depends on lcpf_pkg.
module lcpf_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input lcpf_pkg::result_t             result,
	input logic                          cfg_we,
	input logic [lcpf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input lcpf_pkg::data_t               cfg_wdata
);
	import lcpf_pkg::*;

	logic [7:0] cnt_q;
	logic       zone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			zone_q <= 1'b0;
		end else begin
			if (cnt_q != 8'(TOP_LAT)) begin
				cnt_q <= cnt_q + 8'd1;
			end
			if (cfg_we && cfg_idx == CFG_ZONEOUT_EN) begin
				zone_q <= cfg_wdata[0];
			end
		end
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 8'(TOP_LAT)) |-> (done == $past(start && !busy, TOP_LAT)))
		else $error("result count or timing mismatch");

	a_no_zone_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !zone_q) |-> (result.cell_out == result.cell_raw))
		else $error("cell_out differs from cell_raw with zoneout off");

	a_hidden_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !zone_q) |-> (result.hidden_out <= 16'sd4096
			&& result.hidden_out >= -16'sd4096))
		else $error("hidden out of tanh*sigmoid range");

endmodule

bind lstm_cell_pointwise_forward lcpf_chk u_chk (.*);

/* verif/tb_lstm_cell_pointwise_forward.sv */
// Testbench for lstm_cell_pointwise_forward: directed and random LSTM unit
// requests checked against a bit-exact fixed-point model of the cell update.
// Depends on lcpf_pkg and the block itself.
module tb_lstm_cell_pointwise_forward;
	import lcpf_pkg::*;

	localparam longint unsigned ONE32   = 64'd1 << 32;
	localparam longint unsigned ONE31   = 64'd1 << 31;
	localparam longint unsigned LN2_FIX = 64'd2977044472;
	localparam int              LAT     = 164;
	localparam int              TIMEOUT = 200000;

	logic    clk = 0;
	logic    arst_n = 0;
	logic    start = 0;
	logic    busy;
	item_t   item = '0;
	logic    done;
	result_t result;
	logic    cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_FORGET_BIAS;
	data_t   cfg_wdata = '0;

	lstm_cell_pointwise_forward dut (.*);

	always #5 clk = ~clk;

	longint   bias_q;
	bit       zone_q;
	bit       calm;
	int       errors = 0;
	int       sent = 0;
	int       checked = 0;
	int       cycles = 0;
	result_t  pending[$];

	// exp(-y) in Q32, y with FRAC_W fraction bits
	function automatic longint unsigned exp_neg(longint unsigned y);
		longint unsigned q, k, r, term, pos, neg;
		if (y > (64'd32 << FRAC_W)) y = 64'd32 << FRAC_W;
		q = y << (32 - FRAC_W);
		k = q / LN2_FIX;
		r = q - k * LN2_FIX;
		term = ONE32;
		pos = ONE32;
		neg = 0;
		for (int n = 1; n <= 14; n++) begin
			term = ((term * r) >> 32) / n;
			if (n % 2) neg += term;
			else pos += term;
		end
		if (k >= 40) return 0;
		return (pos - neg) >> k;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint sigmoid_fix(longint x);
		longint unsigned mag, e, part;
		mag = x < 0 ? -x : x;
		e = exp_neg(mag);
		part = (e << 31) / (ONE32 + e);
		return rnd_shift(longint'(x < 0 ? part : ONE31 - part), 31 - FRAC_W);
	endfunction

	function automatic longint tanh_fix(longint x);
		longint unsigned mag, e, t;
		longint r;
		mag = x < 0 ? -x : x;
		if (mag > (64'd16 << FRAC_W)) mag = 64'd16 << FRAC_W;
		e = exp_neg(mag * 2);
		t = ((ONE32 - e) << 31) / (ONE32 + e);
		r = rnd_shift(longint'(t), 31 - FRAC_W);
		return x < 0 ? -r : r;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic result_t predict_cell(item_t it);
		result_t r;
		longint ig, fg, cg, og, cnew, craw, hid;
		ig = sigmoid_fix(longint'(it.pre_input_gate));
		fg = sigmoid_fix(longint'(it.pre_forget_gate) + bias_q);
		cg = tanh_fix(longint'(it.pre_candidate));
		og = sigmoid_fix(longint'(it.pre_output_gate));
		cnew = rnd_shift(cg * ig + longint'(it.prev_cell) * fg, FRAC_W);
		craw = clamp16(cnew);
		hid = clamp16(rnd_shift(tanh_fix(cnew) * og, FRAC_W));
		r.cell_raw = data_t'(craw);
		r.cell_out = data_t'(craw);
		r.hidden_out = data_t'(hid);
		if (zone_q) begin
			if (!it.keep_cell) r.cell_out = it.prev_cell;
			if (!it.keep_hidden) r.hidden_out = it.prev_hidden;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		cycles++;
		if (cycles > TIMEOUT) begin
			$display("timeout at %0t", $time);
			$display("end of test: mismatches");
			$finish;
		end
		if (done) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				want = pending.pop_front();
				checked++;
				if (result.cell_out !== want.cell_out) begin
					$display("%0t: cell_out exp %0d got %0d", $time, want.cell_out,
						result.cell_out);
					errors++;
				end
				if (result.hidden_out !== want.hidden_out) begin
					$display("%0t: hidden_out exp %0d got %0d", $time, want.hidden_out,
						result.hidden_out);
					errors++;
				end
				if (result.cell_raw !== want.cell_raw) begin
					$display("%0t: cell_raw exp %0d got %0d", $time, want.cell_raw,
						result.cell_raw);
					errors++;
				end
			end
		end
	end

	task automatic send_request(item_t it);
		while (!calm && $urandom_range(99) < 14) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		item <= it;
		do @(posedge clk); while (busy);
		pending.push_back(predict_cell(it));
		sent++;
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, data_t val);
		drain();
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_FORGET_BIAS) bias_q = longint'(val);
		else if (idx == CFG_ZONEOUT_EN) zone_q = val[0];
	endtask

	function automatic item_t rand_item();
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom});
		// narrow values keep the activations off their flat tails
		if ($urandom_range(1)) begin
			it.pre_input_gate  = data_t'($signed($urandom_range(16383)) - 8192);
			it.pre_forget_gate = data_t'($signed($urandom_range(16383)) - 8192);
			it.pre_candidate   = data_t'($signed($urandom_range(16383)) - 8192);
			it.pre_output_gate = data_t'($signed($urandom_range(16383)) - 8192);
		end
		return it;
	endfunction

	task automatic test_extremes();
		data_t ext[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
		item_t it;
		for (int i = 0; i < 20; i++) begin
			it.pre_input_gate  = ext[i % 4];
			it.pre_forget_gate = ext[(i / 4) % 4];
			it.pre_candidate   = ext[(i + 1) % 4];
			it.pre_output_gate = ext[(i + 2) % 4];
			it.prev_cell       = ext[(i / 2) % 4];
			it.prev_hidden     = ext[(i + 3) % 4];
			it.keep_hidden     = i[0];
			it.keep_cell       = i[1];
			send_request(it);
		end
	endtask

	task automatic test_random(int n);
		repeat (n) send_request(rand_item());
	endtask

	task automatic test_zoneout();
		write_reg(CFG_ZONEOUT_EN, 16'sd1);
		test_extremes();
		test_random(300);
	endtask

	task automatic test_bias_sweep();
		data_t biases[4] = '{16'sh8000, 16'sh7fff, 16'sh1000, 16'shf000};
		foreach (biases[i]) begin
			write_reg(CFG_FORGET_BIAS, biases[i]);
			write_reg(CFG_ZONEOUT_EN, data_t'(i % 2));
			test_extremes();
			test_random(120);
		end
	endtask

	task automatic test_back_to_back();
		calm = 1;
		write_reg(CFG_FORGET_BIAS, data_t'($urandom));
		test_random(300);
		calm = 0;
		write_reg(CFG_ZONEOUT_EN, 16'sd0);
		write_reg(CFG_FORGET_BIAS, 16'sd0);
		test_random(350);
	endtask

	initial begin
		bias_q = 0;
		zone_q = 0;
		calm = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_extremes();
		test_random(300);
		test_zoneout();
		test_bias_sweep();
		test_back_to_back();
		drain();
		repeat (LAT + 10) @(posedge clk);
		$display("sent %0d requests, checked %0d results over bias extremes", sent, checked);
		$display("and zoneout on/off, with random gaps and a gap-free stretch");
		if (errors == 0 && pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
